[rtl/lav_pkg.sv]
// Package for the look-at view matrix core: shared constants, status codes and
// the pipeline side-band types. No dependencies.
package lav_pkg;

	localparam int UNIT_FRAC_BITS = 30;
	localparam int VEC_W          = 65;
	localparam int SQRT_STEPS     = 32;
	localparam int DIV_STEPS      = 31;

	localparam logic [31:0] UNIT_ONE   = 32'(1) << UNIT_FRAC_BITS;
	localparam logic [43:0] NEAR_LIMIT = 44'd1152921504607;

	localparam logic [1:0] REG_UP_X = 2'd0;
	localparam logic [1:0] REG_UP_Y = 2'd1;
	localparam logic [1:0] REG_UP_Z = 2'd2;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP    = 2'd1;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	typedef enum logic [1:0] {
		ST_NORMAL,
		ST_FALLBACK,
		ST_ZERO_FWD,
		ST_PARALLEL
	} status_t;

	typedef logic [2:0][VEC_W-1:0] vec3_t;
	typedef logic [2:0][31:0]      unit3_t;

	typedef struct packed {
		unit3_t  eye;
		unit3_t  f;
		status_t status;
	} side_t;

	typedef struct packed {
		logic [2:0][30:0] a;
		logic [2:0]       neg;
		logic             zero;
		side_t            side;
	} nc_t;

endpackage

[rtl/look_at_view_matrix_core.sv]
// Top level of the look-at view matrix core: input and output stream ports,
// up-vector registers, cross products, dot products and row output buffer.
// Depends on lav_pkg and lav_norm.
//
// Channel   Direction  Transaction
// s_axis    in         one camera: eye and target points, Q24.8
// m_axis    out        one matrix row; three rows per camera, tlast on the third
// cfg       in         one write of up_x, up_y or up_z, Q1.30
//
// Each camera is sent as three rows from the row buffer, and the
// whole pipeline advances only when the buffer takes a new camera.
// The pipeline holds two normalizers, each with a 32-step square root and a
// 31-step divider, one step per stage.
// Reset clears all valid bits and sets the up vector to +Y.
// An output stall freezes every stage; nothing is dropped or repeated.
module look_at_view_matrix_core import lav_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// eye_x, eye_y, eye_z, target_x, target_y, target_z
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// rot_a, rot_b, rot_c, offset, four zero bits
	output logic [135:0] m_axis_tdata,
	// row_index, status
	output logic [3:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	function automatic logic signed [36:0] rnd30(input logic signed [65:0] x);
		logic [65:0] m;
		logic [65:0] r;
		m = x[65] ? (~x + 66'd1) : x;
		r = (m + (66'd1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
		return x[65] ? -$signed(r[36:0]) : $signed(r[36:0]);
	endfunction

	function automatic logic [35:0] off_of(input logic signed [65:0] x, input logic negate);
		logic signed [37:0] t;
		logic signed [36:0] r;
		r = rnd30(x);
		t = {r[36], r};
		if (negate) t = -t;
		if (t > $signed(38'((38'd1 << 35) - 38'd1))) return {1'b0, {35{1'b1}}};
		else if (t < -$signed(38'(38'd1 << 35))) return {1'b1, 35'b0};
		else return t[35:0];
	endfunction

	logic en;
	logic signed [31:0] up_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= '0;
			up_q[1] <= $signed(UNIT_ONE);
			up_q[2] <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_UP_X: up_q[0] <= cfg_wr_data;
				REG_UP_Y: up_q[1] <= cfg_wr_data;
				REG_UP_Z: up_q[2] <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	unit3_t eye_s1, tgt_s1;
	vec3_t fwd_s2;
	side_t side_s2;

	logic n1_valid, n2_valid;
	unit3_t n1_unit, n2_unit;
	side_t n1_side, n2_side;

	logic signed [63:0] xp_s3 [6];
	unit3_t f_s3, f_s4, f_s5, f_s6;
	side_t side_s3, side_s4, side_s5, side_s6, side_s7;
	logic signed [64:0] r_s4 [3];
	logic signed [64:0] r_s5 [3];
	logic signed [64:0] r_s6 [3];
	logic [2:0][20:0] qr_s5;
	logic [1:0][20:0] qf_s5;
	logic big_r_s5, big_f_s5, big_r_s6, big_f_s6;
	logic [2:0][41:0] sqr_s6;
	logic [1:0][41:0] sqf_s6;
	vec3_t vec_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= n1_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= n2_valid;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= s_axis_tdata[32*i +: 32];
				tgt_s1[i] <= s_axis_tdata[96 + 32*i +: 32];
			end
			for (int i = 0; i < 3; i++) begin
				logic [32:0] d;
				d = {tgt_s1[i][31], tgt_s1[i]} - {eye_s1[i][31], eye_s1[i]};
				fwd_s2[i] <= {{32{d[32]}}, d};
			end
			side_s2.eye <= eye_s1;
			side_s2.f <= '0;
			side_s2.status <= (tgt_s1 == eye_s1) ? ST_ZERO_FWD : ST_NORMAL;
		end
	end

	lav_norm u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_vec    (fwd_s2),
		.in_side   (side_s2),
		.out_valid (n1_valid),
		.out_unit  (n1_unit),
		.out_side  (n1_side)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			xp_s3[0] <= $signed(n1_unit[1]) * up_q[2];
			xp_s3[1] <= $signed(n1_unit[2]) * up_q[1];
			xp_s3[2] <= $signed(n1_unit[2]) * up_q[0];
			xp_s3[3] <= $signed(n1_unit[0]) * up_q[2];
			xp_s3[4] <= $signed(n1_unit[0]) * up_q[1];
			xp_s3[5] <= $signed(n1_unit[1]) * up_q[0];
			f_s3 <= n1_unit;
			side_s3 <= n1_side;

			r_s4[0] <= xp_s3[0] - xp_s3[1];
			r_s4[1] <= xp_s3[2] - xp_s3[3];
			r_s4[2] <= xp_s3[4] - xp_s3[5];
			f_s4 <= f_s3;
			side_s4 <= side_s3;

			begin
				logic [64:0] m;
				logic big;
				big = 1'b0;
				for (int i = 0; i < 3; i++) begin
					m = r_s4[i][64] ? (~r_s4[i] + 65'd1) : r_s4[i];
					qr_s5[i] <= m[50:30];
					if (|m[64:51]) big = 1'b1;
				end
				big_r_s5 <= big;
			end
			begin
				logic [31:0] m0, m1;
				m0 = f_s4[1][31] ? (~f_s4[1] + 32'd1) : f_s4[1];
				m1 = f_s4[0][31] ? (~f_s4[0] + 32'd1) : f_s4[0];
				qf_s5[0] <= m0[20:0];
				qf_s5[1] <= m1[20:0];
				big_f_s5 <= (|m0[31:21]) || (|m1[31:21]);
			end
			r_s5 <= r_s4;
			f_s5 <= f_s4;
			side_s5 <= side_s4;

			for (int i = 0; i < 3; i++) sqr_s6[i] <= 42'(qr_s5[i]) * 42'(qr_s5[i]);
			for (int i = 0; i < 2; i++) sqf_s6[i] <= 42'(qf_s5[i]) * 42'(qf_s5[i]);
			big_r_s6 <= big_r_s5;
			big_f_s6 <= big_f_s5;
			r_s6 <= r_s5;
			f_s6 <= f_s5;
			side_s6 <= side_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			logic [43:0] sum_r, sum_f;
			logic near_r, near_f;
			side_t sd;
			vec3_t vc;
			sum_r = 44'(sqr_s6[0]) + 44'(sqr_s6[1]) + 44'(sqr_s6[2]);
			sum_f = 44'(sqf_s6[0]) + 44'(sqf_s6[1]);
			near_r = !big_r_s6 && (sum_r < NEAR_LIMIT);
			near_f = !big_f_s6 && (sum_f < NEAR_LIMIT);
			sd = side_s6;
			sd.f = f_s6;
			for (int i = 0; i < 3; i++) vc[i] = r_s6[i];
			if (side_s6.status != ST_ZERO_FWD && near_r) begin
				vc[0] = {{3{f_s6[1][31]}}, f_s6[1], 30'b0};
				vc[1] = ~{{3{f_s6[0][31]}}, f_s6[0], 30'b0} + 65'd1;
				vc[2] = '0;
				sd.status = near_f ? ST_PARALLEL : ST_FALLBACK;
			end
			side_s7 <= sd;
			vec_s7 <= vc;
		end
	end

	lav_norm u_norm_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_vec    (vec_s7),
		.in_side   (side_s7),
		.out_valid (n2_valid),
		.out_unit  (n2_unit),
		.out_side  (n2_side)
	);

	logic signed [63:0] cp_s8 [6];
	logic signed [63:0] dr_s8 [3];
	logic signed [63:0] df_s8 [3];
	unit3_t rn_s8, rn_s9, rn_s10, rn_s11, rn_s12;
	side_t side_s8, side_s9, side_s10, side_s11, side_s12;
	logic signed [64:0] tmp_s9 [3];
	logic signed [65:0] dsr_s9, dsr_s10, dsr_s11, dsr_s12;
	logic signed [65:0] dsf_s9, dsf_s10, dsf_s11, dsf_s12;
	unit3_t u_s10, u_s11, u_s12;
	logic signed [63:0] du_s11 [3];
	logic signed [65:0] dsu_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s8[0] <= $signed(n2_unit[1]) * $signed(n2_side.f[2]);
			cp_s8[1] <= $signed(n2_unit[2]) * $signed(n2_side.f[1]);
			cp_s8[2] <= $signed(n2_unit[2]) * $signed(n2_side.f[0]);
			cp_s8[3] <= $signed(n2_unit[0]) * $signed(n2_side.f[2]);
			cp_s8[4] <= $signed(n2_unit[0]) * $signed(n2_side.f[1]);
			cp_s8[5] <= $signed(n2_unit[1]) * $signed(n2_side.f[0]);
			for (int i = 0; i < 3; i++) begin
				dr_s8[i] <= $signed(n2_unit[i]) * $signed(n2_side.eye[i]);
				df_s8[i] <= $signed(n2_side.f[i]) * $signed(n2_side.eye[i]);
			end
			rn_s8 <= n2_unit;
			side_s8 <= n2_side;

			tmp_s9[0] <= cp_s8[0] - cp_s8[1];
			tmp_s9[1] <= cp_s8[2] - cp_s8[3];
			tmp_s9[2] <= cp_s8[4] - cp_s8[5];
			dsr_s9 <= 66'(dr_s8[0]) + 66'(dr_s8[1]) + 66'(dr_s8[2]);
			dsf_s9 <= 66'(df_s8[0]) + 66'(df_s8[1]) + 66'(df_s8[2]);
			rn_s9 <= rn_s8;
			side_s9 <= side_s8;

			for (int i = 0; i < 3; i++) begin
				logic signed [36:0] r;
				r = rnd30({tmp_s9[i][64], tmp_s9[i]});
				if (r > $signed({5'b0, UNIT_ONE})) u_s10[i] <= UNIT_ONE;
				else if (r < -$signed({5'b0, UNIT_ONE})) u_s10[i] <= ~UNIT_ONE + 32'd1;
				else u_s10[i] <= r[31:0];
			end
			dsr_s10 <= dsr_s9;
			dsf_s10 <= dsf_s9;
			rn_s10 <= rn_s9;
			side_s10 <= side_s9;

			for (int i = 0; i < 3; i++) du_s11[i] <= $signed(u_s10[i]) * $signed(side_s10.eye[i]);
			u_s11 <= u_s10;
			dsr_s11 <= dsr_s10;
			dsf_s11 <= dsf_s10;
			rn_s11 <= rn_s10;
			side_s11 <= side_s10;

			dsu_s12 <= 66'(du_s11[0]) + 66'(du_s11[1]) + 66'(du_s11[2]);
			u_s12 <= u_s11;
			dsr_s12 <= dsr_s11;
			dsf_s12 <= dsf_s11;
			rn_s12 <= rn_s11;
			side_s12 <= side_s11;
		end
	end

	unit3_t rot_s13 [3];
	logic [35:0] off_s13 [3];
	status_t st_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			st_s13 <= side_s12.status;
			if (side_s12.status == ST_ZERO_FWD || side_s12.status == ST_PARALLEL) begin
				for (int k = 0; k < 3; k++) begin
					unit3_t id;
					id = '0;
					id[k] = UNIT_ONE;
					rot_s13[k] <= id;
					off_s13[k] <= '0;
				end
			end else begin
				rot_s13[0] <= rn_s12;
				rot_s13[1] <= u_s12;
				for (int i = 0; i < 3; i++) rot_s13[2][i] <= ~side_s12.f[i] + 32'd1;
				off_s13[0] <= off_of(dsr_s12, 1'b1);
				off_s13[1] <= off_of(dsu_s12, 1'b1);
				off_s13[2] <= off_of(dsf_s12, 1'b0);
			end
		end
	end

	logic ob_valid_q;
	logic [1:0] row_q;
	unit3_t ob_rot_q [3];
	logic [35:0] ob_off_q [3];
	status_t ob_st_q;

	assign en = !ob_valid_q || (m_axis_tready && row_q == ROW_LAST);
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			row_q <= ROW_RIGHT;
		end else if (en) begin
			ob_valid_q <= v_s13;
			row_q <= ROW_RIGHT;
		end else if (m_axis_tready) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ob_rot_q <= rot_s13;
			ob_off_q <= off_s13;
			ob_st_q <= st_s13;
		end
	end

	always_comb begin
		case (row_q)
			ROW_UP:   m_axis_tdata = {4'b0, ob_off_q[1], ob_rot_q[1][2], ob_rot_q[1][1], ob_rot_q[1][0]};
			ROW_LAST: m_axis_tdata = {4'b0, ob_off_q[2], ob_rot_q[2][2], ob_rot_q[2][1], ob_rot_q[2][0]};
			default:  m_axis_tdata = {4'b0, ob_off_q[0], ob_rot_q[0][2], ob_rot_q[0][1], ob_rot_q[0][0]};
		endcase
	end

	assign m_axis_tvalid = ob_valid_q;
	assign m_axis_tuser  = {ob_st_q, row_q};
	assign m_axis_tlast  = (row_q == ROW_LAST);

endmodule

[rtl/lav_norm.sv]
// Pipelined vector normalizer: magnitude, scaling, integer square root and
// three-lane restoring division, one step per stage. Depends on lav_pkg.
module lav_norm import lav_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  vec3_t  in_vec,
	input  side_t  in_side,
	output logic   out_valid,
	output unit3_t out_unit,
	output side_t  out_side
);

	function automatic logic [4:0] lzc16(input logic [15:0] x);
		logic [4:0] n;
		logic       found;
		n = 5'd16;
		found = 1'b0;
		for (int k = 15; k >= 0; k--) begin
			if (!found && x[k]) begin
				n = 5'(15 - k);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [2:0][63:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0] neg_s1, neg_s2, neg_s3, neg_s4;
	side_t side_s1, side_s2, side_s3, side_s4;
	logic [63:0] mx_s2;
	logic [3:0] nz_s3;
	logic [3:0][4:0] clz_s3;
	logic [6:0] lz_s4;
	nc_t c_s5, c_s6, c_s7, c_n;
	logic [2:0][61:0] sqa_s6;
	logic [63:0] sum_s7;

	logic [63:0] mx_n;
	logic [6:0]  lz_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		mx_n = mag_s1[0];
		if (mag_s1[1] > mx_n) mx_n = mag_s1[1];
		if (mag_s1[2] > mx_n) mx_n = mag_s1[2];
	end

	always_comb begin
		if (nz_s3[3]) lz_n = 7'(clz_s3[3]);
		else if (nz_s3[2]) lz_n = 7'd16 + 7'(clz_s3[2]);
		else if (nz_s3[1]) lz_n = 7'd32 + 7'(clz_s3[1]);
		else if (nz_s3[0]) lz_n = 7'd48 + 7'(clz_s3[0]);
		else lz_n = 7'd64;
	end

	always_comb begin
		logic [63:0] sh;
		c_n.neg  = neg_s4;
		c_n.side = side_s4;
		c_n.zero = (lz_s4 == 7'd64);
		for (int i = 0; i < 3; i++) begin
			if (lz_s4 <= 7'd33) sh = mag_s4[i] >> (7'd33 - lz_s4);
			else sh = mag_s4[i] << (lz_s4 - 7'd33);
			c_n.a[i] = sh[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_vec[i][VEC_W-1] ? 64'(~in_vec[i] + 65'd1) : in_vec[i][63:0];
				neg_s1[i] <= in_vec[i][VEC_W-1];
			end
			side_s1 <= in_side;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			mx_s2   <= mx_n;
			for (int c = 0; c < 4; c++) begin
				nz_s3[c]  <= |mx_s2[16*c +: 16];
				clz_s3[c] <= lzc16(mx_s2[16*c +: 16]);
			end
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
			lz_s4   <= lz_n;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			side_s4 <= side_s3;
			c_s5    <= c_n;
			for (int i = 0; i < 3; i++) begin
				sqa_s6[i] <= 62'(c_s5.a[i]) * 62'(c_s5.a[i]);
			end
			c_s6   <= c_s5;
			sum_s7 <= 64'(sqa_s6[0]) + 64'(sqa_s6[1]) + 64'(sqa_s6[2]);
			c_s7   <= c_s6;
		end
	end

	logic [33:0] sr_rem_s  [1:SQRT_STEPS];
	logic [31:0] sr_root_s [1:SQRT_STEPS];
	logic [63:0] sr_x_s    [1:SQRT_STEPS];
	nc_t         sr_c_s    [1:SQRT_STEPS];
	logic        sr_v_s    [1:SQRT_STEPS];

	genvar j;
	generate
		for (j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
			logic [33:0] rem_i;
			logic [31:0] root_i;
			logic [63:0] x_i;
			nc_t         c_i;
			logic        v_i;
			logic [35:0] t;
			logic [35:0] trial;
			logic        ge;
			if (j == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign x_i    = sum_s7;
				assign c_i    = c_s7;
				assign v_i    = v_s7;
			end else begin : g_next
				assign rem_i  = sr_rem_s[j];
				assign root_i = sr_root_s[j];
				assign x_i    = sr_x_s[j];
				assign c_i    = sr_c_s[j];
				assign v_i    = sr_v_s[j];
			end
			assign t     = {rem_i, x_i[2*(SQRT_STEPS-1-j) +: 2]};
			assign trial = {2'b00, root_i, 2'b01};
			assign ge    = (t >= trial);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) sr_v_s[j+1] <= 1'b0;
				else if (en) sr_v_s[j+1] <= v_i;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					sr_rem_s[j+1]  <= ge ? 34'(t - trial) : t[33:0];
					sr_root_s[j+1] <= {root_i[30:0], ge};
					sr_x_s[j+1]    <= x_i;
					sr_c_s[j+1]    <= c_i;
				end
			end
		end
	endgenerate

	logic [2:0][61:0] dp_n_s;
	logic [31:0]      dp_len_s;
	nc_t              dp_c_s;
	logic             dp_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dp_v_s <= 1'b0;
		else if (en) dp_v_s <= sr_v_s[SQRT_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dp_n_s[i] <= 62'({sr_c_s[SQRT_STEPS].a[i], 30'b0})
					+ 62'(sr_root_s[SQRT_STEPS] >> 1);
			end
			dp_len_s <= sr_root_s[SQRT_STEPS];
			dp_c_s   <= sr_c_s[SQRT_STEPS];
		end
	end

	logic [2:0][31:0] dv_rem_s [1:DIV_STEPS];
	logic [2:0][30:0] dv_q_s   [1:DIV_STEPS];
	logic [2:0][61:0] dv_n_s   [1:DIV_STEPS];
	logic [31:0]      dv_len_s [1:DIV_STEPS];
	nc_t              dv_c_s   [1:DIV_STEPS];
	logic             dv_v_s   [1:DIV_STEPS];

	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_div
			logic [2:0][31:0] rem_i;
			logic [2:0][30:0] q_i;
			logic [2:0][61:0] n_i;
			logic [31:0]      len_i;
			nc_t              c_i;
			logic             v_i;
			logic [2:0][32:0] t;
			logic [2:0]       ge;
			if (j == 0) begin : g_first
				for (genvar i = 0; i < 3; i++) begin : g_lane
					assign rem_i[i] = {1'b0, dp_n_s[i][61:31]};
				end
				assign q_i   = '0;
				assign n_i   = dp_n_s;
				assign len_i = dp_len_s;
				assign c_i   = dp_c_s;
				assign v_i   = dp_v_s;
			end else begin : g_next
				assign rem_i = dv_rem_s[j];
				assign q_i   = dv_q_s[j];
				assign n_i   = dv_n_s[j];
				assign len_i = dv_len_s[j];
				assign c_i   = dv_c_s[j];
				assign v_i   = dv_v_s[j];
			end
			for (genvar i = 0; i < 3; i++) begin : g_step
				assign t[i]  = {rem_i[i], n_i[i][DIV_STEPS-1-j]};
				assign ge[i] = (t[i] >= {1'b0, len_i});
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) dv_v_s[j+1] <= 1'b0;
				else if (en) dv_v_s[j+1] <= v_i;
			end
			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 3; i++) begin
						dv_rem_s[j+1][i] <= ge[i] ? 32'(t[i] - {1'b0, len_i}) : t[i][31:0];
						dv_q_s[j+1][i]   <= {q_i[i][29:0], ge[i]};
					end
					dv_n_s[j+1]   <= n_i;
					dv_len_s[j+1] <= len_i;
					dv_c_s[j+1]   <= c_i;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [31:0] c;
				c = ({1'b0, dv_q_s[DIV_STEPS][i]} > UNIT_ONE) ? UNIT_ONE
					: {1'b0, dv_q_s[DIV_STEPS][i]};
				if (dv_c_s[DIV_STEPS].zero) out_unit[i] <= '0;
				else if (dv_c_s[DIV_STEPS].neg[i]) out_unit[i] <= ~c + 32'd1;
				else out_unit[i] <= c;
			end
			out_side <= dv_c_s[DIV_STEPS].side;
		end
	end

endmodule

[rtl/lav_checker.sv]
// Port-level checker for the look-at view matrix core, bound to the top level.
// Depends on lav_pkg.
module lav_checker import lav_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == ROW_LAST)))
		else $error("tlast does not mark the third row");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tuser[1:0] == $past(m_axis_tuser[1:0]) + 2'd1)
		else $error("row sequence broken");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input accepted in the middle of a row run");

	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[3:2] == ST_ZERO_FWD || m_axis_tuser[3:2] == ST_PARALLEL)
			|-> m_axis_tdata[131:96] == 36'd0)
		else $error("identity row with nonzero offset");

endmodule

bind look_at_view_matrix_core lav_checker u_lav_checker (.*);
